// File: rtl/segi_pkg.sv
// ----------------------------------------------------------------------------
// segi_pkg
// Shared widths, types, codes and helpers of the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CRS_W      = PROD_W + 1;
    localparam int NUM_W      = CRS_W + DIFF_W + 1;

    // cross product slots
    localparam int NCR    = 9;
    localparam int CR_L1  = 0;
    localparam int CR_R1  = 1;
    localparam int CR_L2  = 2;
    localparam int CR_R2  = 3;
    localparam int CR_L3  = 4;
    localparam int CR_R3  = 5;
    localparam int CR_L4  = 6;
    localparam int CR_R4  = 7;
    localparam int CR_DET = 8;

    typedef enum logic [2:0] {
        HOW_NONE   = 3'd0,
        HOW_CALC   = 3'd1,
        HOW_END1   = 3'd2,
        HOW_START1 = 3'd3,
        HOW_COLL   = 3'd4
    } t_how;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
    } t_pts;

    typedef struct packed {
        logic eq_bc;
        logic eq_bd;
        logic eq_ac;
        logic eq_ad;
        logic bbox_rej;
    } t_flags;

    typedef struct packed {
        t_pts                     pts;
        t_flags                   flg;
        logic signed [DIFF_W-1:0] ux;
        logic signed [DIFF_W-1:0] uy;
        logic signed [DIFF_W-1:0] vx;
        logic signed [DIFF_W-1:0] vy;
        logic signed [DIFF_W-1:0] cax;
        logic signed [DIFF_W-1:0] cay;
        logic signed [DIFF_W-1:0] dax;
        logic signed [DIFF_W-1:0] day;
        logic signed [DIFF_W-1:0] cbx;
        logic signed [DIFF_W-1:0] cby;
        logic signed [DIFF_W-1:0] dbx;
        logic signed [DIFF_W-1:0] dby;
    } t_f1;

    typedef struct packed {
        t_pts                           pts;
        t_flags                         flg;
        logic signed [DIFF_W-1:0]       ux;
        logic signed [DIFF_W-1:0]       uy;
        logic [NCR-1:0][PROD_W-1:0]     pa;
        logic [NCR-1:0][PROD_W-1:0]     pb;
    } t_f2;

    typedef struct packed {
        t_pts                           pts;
        t_flags                         flg;
        logic signed [DIFF_W-1:0]       ux;
        logic signed [DIFF_W-1:0]       uy;
        logic [NCR-1:0][CRS_W-1:0]      cr;
    } t_crs;

    typedef struct packed {
        logic                         hit;
        t_how                         how;
        logic signed [COORD_BITS-1:0] alt_x;
        logic signed [COORD_BITS-1:0] alt_y;
    } t_side;

    typedef struct packed {
        t_side                     side;
        logic signed [CRS_W-1:0]   den;
        logic signed [NUM_W-1:0]   mx1;
        logic signed [NUM_W-1:0]   mux;
        logic signed [NUM_W-1:0]   my1;
        logic signed [NUM_W-1:0]   muy;
    } t_d1;

    typedef struct packed {
        t_side                  side;
        logic [CRS_W-1:0]       den_mag;
        logic [NUM_W-1:0]       nx_mag;
        logic [NUM_W-1:0]       ny_mag;
        logic                   negx;
        logic                   negy;
        logic [COORD_BITS-1:0]  qx;
        logic [COORD_BITS-1:0]  qy;
    } t_div;

    // both nonzero and of one sign: the pair lies on one side
    function automatic logic same_side(logic [CRS_W-1:0] a, logic [CRS_W-1:0] b);
        return (a != '0) && (b != '0) && (a[CRS_W-1] == b[CRS_W-1]);
    endfunction

endpackage

// File: rtl/segi_front.sv
// ----------------------------------------------------------------------------
// segi_front
// Differences and bounding box, then products, then the nine cross products.
// ----------------------------------------------------------------------------
module segi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  segi_pkg::t_pts i_pts,
    output logic          o_valid,
    output segi_pkg::t_crs o_crs
);
    import segi_pkg::*;

    logic r_f1_valid, n_f1_valid;
    logic r_f2_valid;
    logic r_f3_valid;
    t_f1  r_f1, n_f1;
    t_f2  r_f2, n_f2;
    t_crs r_f3, n_f3;

    logic signed [DIFF_W-1:0] wx [NCR];
    logic signed [DIFF_W-1:0] wy [NCR];
    logic signed [DIFF_W-1:0] zx [NCR];
    logic signed [DIFF_W-1:0] zy [NCR];

    // stage 1: edge vectors, endpoint equality, bounding-box reject
    always_comb begin
        n_f1_valid   = i_valid;
        n_f1.pts     = i_pts;
        n_f1.ux      = i_pts.bx - i_pts.ax;
        n_f1.uy      = i_pts.by - i_pts.ay;
        n_f1.vx      = i_pts.dx - i_pts.cx;
        n_f1.vy      = i_pts.dy - i_pts.cy;
        n_f1.cax     = i_pts.cx - i_pts.ax;
        n_f1.cay     = i_pts.cy - i_pts.ay;
        n_f1.dax     = i_pts.dx - i_pts.ax;
        n_f1.day     = i_pts.dy - i_pts.ay;
        n_f1.cbx     = i_pts.cx - i_pts.bx;
        n_f1.cby     = i_pts.cy - i_pts.by;
        n_f1.dbx     = i_pts.dx - i_pts.bx;
        n_f1.dby     = i_pts.dy - i_pts.by;
        n_f1.flg.eq_bc = (i_pts.bx == i_pts.cx) && (i_pts.by == i_pts.cy);
        n_f1.flg.eq_bd = (i_pts.bx == i_pts.dx) && (i_pts.by == i_pts.dy);
        n_f1.flg.eq_ac = (i_pts.ax == i_pts.cx) && (i_pts.ay == i_pts.cy);
        n_f1.flg.eq_ad = (i_pts.ax == i_pts.dx) && (i_pts.ay == i_pts.dy);
        // a box is clear of the other when every corner pair is apart
        n_f1.flg.bbox_rej =
            ((i_pts.ax > i_pts.cx) && (i_pts.ax > i_pts.dx) &&
             (i_pts.bx > i_pts.cx) && (i_pts.bx > i_pts.dx)) ||
            ((i_pts.cx > i_pts.ax) && (i_pts.cx > i_pts.bx) &&
             (i_pts.dx > i_pts.ax) && (i_pts.dx > i_pts.bx)) ||
            ((i_pts.ay > i_pts.cy) && (i_pts.ay > i_pts.dy) &&
             (i_pts.by > i_pts.cy) && (i_pts.by > i_pts.dy)) ||
            ((i_pts.cy > i_pts.ay) && (i_pts.cy > i_pts.by) &&
             (i_pts.dy > i_pts.ay) && (i_pts.dy > i_pts.by));
    end

    // stage 2: operand routing and the two products of each cross
    always_comb begin
        wx[CR_L1] = r_f1.ux;  wy[CR_L1] = r_f1.uy;  zx[CR_L1] = r_f1.cax; zy[CR_L1] = r_f1.cay;
        wx[CR_R1] = r_f1.ux;  wy[CR_R1] = r_f1.uy;  zx[CR_R1] = r_f1.dax; zy[CR_R1] = r_f1.day;
        wx[CR_L2] = r_f1.ux;  wy[CR_L2] = r_f1.uy;  zx[CR_L2] = r_f1.cbx; zy[CR_L2] = r_f1.cby;
        wx[CR_R2] = r_f1.ux;  wy[CR_R2] = r_f1.uy;  zx[CR_R2] = r_f1.dbx; zy[CR_R2] = r_f1.dby;
        wx[CR_L3] = r_f1.vx;  wy[CR_L3] = r_f1.vy;  zx[CR_L3] = r_f1.cax; zy[CR_L3] = r_f1.cay;
        wx[CR_R3] = r_f1.vx;  wy[CR_R3] = r_f1.vy;  zx[CR_R3] = r_f1.cbx; zy[CR_R3] = r_f1.cby;
        wx[CR_L4] = r_f1.vx;  wy[CR_L4] = r_f1.vy;  zx[CR_L4] = r_f1.dax; zy[CR_L4] = r_f1.day;
        wx[CR_R4] = r_f1.vx;  wy[CR_R4] = r_f1.vy;  zx[CR_R4] = r_f1.dbx; zy[CR_R4] = r_f1.dby;
        wx[CR_DET] = r_f1.ux; wy[CR_DET] = r_f1.uy; zx[CR_DET] = r_f1.vx; zy[CR_DET] = r_f1.vy;
        n_f2.pts = r_f1.pts;
        n_f2.flg = r_f1.flg;
        n_f2.ux  = r_f1.ux;
        n_f2.uy  = r_f1.uy;
        for (int i = 0; i < NCR; i++) begin
            n_f2.pa[i] = PROD_W'(wx[i] * zy[i]);
            n_f2.pb[i] = PROD_W'(wy[i] * zx[i]);
        end
    end

    // stage 3: finish each cross product
    always_comb begin
        n_f3.pts = r_f2.pts;
        n_f3.flg = r_f2.flg;
        n_f3.ux  = r_f2.ux;
        n_f3.uy  = r_f2.uy;
        for (int i = 0; i < NCR; i++) begin
            n_f3.cr[i] = CRS_W'($signed(r_f2.pa[i])) - CRS_W'($signed(r_f2.pb[i]));
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else if (i_en) begin
            r_f1_valid <= n_f1_valid;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
            r_f3 <= n_f3;
        end
    end

    assign o_valid = r_f3_valid;
    assign o_crs   = r_f3;

endmodule

// File: rtl/segi_decide.sv
// ----------------------------------------------------------------------------
// segi_decide
// Ordered touch and straddle decisions, numerator products, then magnitudes
// and signs for the divider.
// ----------------------------------------------------------------------------
module segi_decide (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  segi_pkg::t_crs i_crs,
    output logic           o_valid,
    output segi_pkg::t_div o_div
);
    import segi_pkg::*;

    logic r_d1_valid;
    logic r_d2_valid;
    t_d1  r_d1, n_d1;
    t_div r_d2, n_d2;

    logic signed [CRS_W-1:0] det;
    logic signed [CRS_W-1:0] tn;
    logic signed [NUM_W-1:0] nx;
    logic signed [NUM_W-1:0] ny;

    // stage 1: decide in order, start the numerator products
    always_comb begin
        det = $signed(i_crs.cr[CR_DET]);
        tn  = -$signed(i_crs.cr[CR_L3]);
        n_d1.side.hit   = 1'b1;
        n_d1.side.how   = HOW_NONE;
        n_d1.side.alt_x = '0;
        n_d1.side.alt_y = '0;
        if (i_crs.flg.bbox_rej) begin
            n_d1.side.hit = 1'b0;
        end else if (((i_crs.cr[CR_L1] == '0) && i_crs.flg.eq_bc) ||
                     ((i_crs.cr[CR_R1] == '0) && i_crs.flg.eq_bd)) begin
            n_d1.side.how   = HOW_END1;
            n_d1.side.alt_x = i_crs.pts.bx;
            n_d1.side.alt_y = i_crs.pts.by;
        end else if (same_side(i_crs.cr[CR_L1], i_crs.cr[CR_R1])) begin
            n_d1.side.hit = 1'b0;
        end else if (((i_crs.cr[CR_L2] == '0) && i_crs.flg.eq_ac) ||
                     ((i_crs.cr[CR_R2] == '0) && i_crs.flg.eq_ad)) begin
            n_d1.side.how   = HOW_START1;
            n_d1.side.alt_x = i_crs.pts.ax;
            n_d1.side.alt_y = i_crs.pts.ay;
        end else if (same_side(i_crs.cr[CR_L2], i_crs.cr[CR_R2]) ||
                     same_side(i_crs.cr[CR_L3], i_crs.cr[CR_R3]) ||
                     same_side(i_crs.cr[CR_L4], i_crs.cr[CR_R4])) begin
            n_d1.side.hit = 1'b0;
        end else if (det == '0) begin
            n_d1.side.how   = HOW_COLL;
            n_d1.side.alt_x = i_crs.pts.cx;
            n_d1.side.alt_y = i_crs.pts.cy;
        end else begin
            n_d1.side.how = HOW_CALC;
        end
        n_d1.den = det;
        n_d1.mx1 = NUM_W'(i_crs.pts.ax * det);
        n_d1.my1 = NUM_W'(i_crs.pts.ay * det);
        n_d1.mux = NUM_W'(i_crs.ux * tn);
        n_d1.muy = NUM_W'(i_crs.uy * tn);
    end

    // stage 2: sum numerators, split into sign and magnitude
    always_comb begin
        nx = r_d1.mx1 + r_d1.mux;
        ny = r_d1.my1 + r_d1.muy;
        n_d2.side    = r_d1.side;
        n_d2.den_mag = r_d1.den[CRS_W-1] ? CRS_W'(-r_d1.den) : CRS_W'(r_d1.den);
        n_d2.nx_mag  = nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
        n_d2.ny_mag  = ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
        n_d2.negx    = nx[NUM_W-1] ^ r_d1.den[CRS_W-1];
        n_d2.negy    = ny[NUM_W-1] ^ r_d1.den[CRS_W-1];
        n_d2.qx      = '0;
        n_d2.qy      = '0;
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_valid <= 1'b0;
            r_d2_valid <= 1'b0;
        end else if (i_en) begin
            r_d1_valid <= i_valid;
            r_d2_valid <= r_d1_valid;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1 <= n_d1;
            r_d2 <= n_d2;
        end
    end

    assign o_valid = r_d2_valid;
    assign o_div   = r_d2;

endmodule

// File: rtl/segi_div.sv
// ----------------------------------------------------------------------------
// segi_div
// Restoring divider for both coordinates, one quotient bit per stage.
// ----------------------------------------------------------------------------
module segi_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  segi_pkg::t_div i_div,
    output logic           o_valid,
    output segi_pkg::t_div o_div
);
    import segi_pkg::*;

    logic r_v [COORD_BITS];
    t_div r_d [COORD_BITS];

    for (genvar k = 0; k < COORD_BITS; k++) begin : g_stage
        localparam int SH = COORD_BITS - 1 - k;
        logic            s_v;
        t_div            s_d;
        t_div            n_d;
        logic [NUM_W:0]  trial;

        if (k == 0) begin : g_first
            assign s_v = i_valid;
            assign s_d = i_div;
        end else begin : g_next
            assign s_v = r_v[k-1];
            assign s_d = r_d[k-1];
        end

        // subtract the shifted divisor where it fits
        always_comb begin
            n_d   = s_d;
            trial = (NUM_W + 1)'(s_d.den_mag) << SH;
            if ({1'b0, s_d.nx_mag} >= trial) begin
                n_d.nx_mag = s_d.nx_mag - trial[NUM_W-1:0];
                n_d.qx[SH] = 1'b1;
            end
            if ({1'b0, s_d.ny_mag} >= trial) begin
                n_d.ny_mag = s_d.ny_mag - trial[NUM_W-1:0];
                n_d.qy[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[k] <= n_d;
            end
        end
    end

    assign o_valid = r_v[COORD_BITS-1];
    assign o_div   = r_d[COORD_BITS-1];

endmodule

// File: rtl/segment_intersection.sv
// Pipeline registers from request accepted to result shown: 3 front, 2 decide,
// 16 divider stages, 1 output register.
// Throughput: one request per cycle; the divider yields one quotient bit per stage.
// A stalled output freezes the whole pipeline in place and holds off new requests.
// Reset (synchronous, active low) clears every valid bit; payload is not reset.
// ----------------------------------------------------------------------------
// segment_intersection
// Pipelined test of whether two fixed-point segments meet, and where.
// ----------------------------------------------------------------------------
module segment_intersection (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_ax,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_ay,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_bx,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_by,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_cx,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_cy,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_dx,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_dy,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_hit,
    output logic [2:0]                           o_how_found,
    output logic signed [segi_pkg::COORD_BITS-1:0] o_cross_x,
    output logic signed [segi_pkg::COORD_BITS-1:0] o_cross_y
);
    import segi_pkg::*;

    logic en;
    t_pts pts;
    logic f_valid, d_valid, q_valid;
    t_crs f_crs;
    t_div d_div, q_div;

    logic                         r_valid;
    logic                         r_hit, n_hit;
    logic [2:0]                   r_how, n_how;
    logic signed [COORD_BITS-1:0] r_x, n_x;
    logic signed [COORD_BITS-1:0] r_y, n_y;
    logic signed [COORD_BITS-1:0] qx_s, qy_s;

    // hold everything while the output request waits
    assign en      = !(r_valid && i_stall);
    assign o_stall = !en;

    assign pts = '{ax: i_ax, ay: i_ay, bx: i_bx, by: i_by,
                   cx: i_cx, cy: i_cy, dx: i_dx, dy: i_dy};

    segi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pts   (pts),
        .o_valid (f_valid),
        .o_crs   (f_crs)
    );

    segi_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_crs   (f_crs),
        .o_valid (d_valid),
        .o_div   (d_div)
    );

    segi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_div   (d_div),
        .o_valid (q_valid),
        .o_div   (q_div)
    );

    // restore quotient signs and pick the reported point
    always_comb begin
        qx_s  = q_div.negx ? -$signed(q_div.qx) : $signed(q_div.qx);
        qy_s  = q_div.negy ? -$signed(q_div.qy) : $signed(q_div.qy);
        n_hit = q_div.side.hit;
        n_how = q_div.side.how;
        if (q_div.side.how == HOW_CALC) begin
            n_x = qx_s;
            n_y = qy_s;
        end else begin
            n_x = q_div.side.alt_x;
            n_y = q_div.side.alt_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
            r_how <= n_how;
            r_x   <= n_x;
            r_y   <= n_y;
        end
    end

    assign o_valid     = r_valid;
    assign o_hit       = r_hit;
    assign o_how_found = r_how;
    assign o_cross_x   = r_x;
    assign o_cross_y   = r_y;

endmodule

// File: rtl/segi_check.sv
// ----------------------------------------------------------------------------
// segi_check
// Port-level checks on the segment intersection block, bound to the top.
// ----------------------------------------------------------------------------
module segi_check (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic                                 o_hit,
    input logic [2:0]                           o_how_found,
    input logic signed [segi_pkg::COORD_BITS-1:0] o_cross_x,
    input logic signed [segi_pkg::COORD_BITS-1:0] o_cross_y
);
    import segi_pkg::*;

    // a stalled result request holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cross_x) && $stable(o_cross_y)
            && $stable(o_how_found) && $stable(o_hit))
        else $error("stalled result changed");

    // hit agrees with the way the point was found
    a_hit_how: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit == (o_how_found != HOW_NONE)))
        else $error("hit and how_found disagree");

    // a miss reports the origin
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> (o_cross_x == '0) && (o_cross_y == '0))
        else $error("miss with nonzero point");

    // input is held back only by a waiting result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without cause");

endmodule

bind segment_intersection segi_check u_segi_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_hit       (o_hit),
    .o_how_found (o_how_found),
    .o_cross_x   (o_cross_x),
    .o_cross_y   (o_cross_y)
);

// File: test/segment_intersection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_checker
// Watches both channels of the segment intersection block, works out the
// expected hit, code and point for each accepted request and compares them
// with each accepted result in order.
// ----------------------------------------------------------------------------
module segment_intersection_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   i_in_stall,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_ax,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_ay,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_bx,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_by,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_cx,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_cy,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_dx,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_dy,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic                                   i_hit,
    input  logic [2:0]                             i_how_found,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_cross_x,
    input  logic signed [segi_pkg::COORD_BITS-1:0] i_cross_y,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import segi_pkg::*;

    typedef struct packed {
        logic                         hit;
        t_how                         how;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } t_meet;

    t_meet meet_q[$];

    assign o_pending = meet_q.size();

    function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
        return ux * vy - uy * vx;
    endfunction

    function automatic bit one_side(longint a, longint b);
        return (a > 0 && b > 0) || (a < 0 && b < 0);
    endfunction

    // truncating quotient of an exact numerator, kept wide
    function automatic logic signed [COORD_BITS-1:0] cramer(longint p0, longint u,
                                                            longint tn, longint det);
        logic signed [127:0] num;
        logic signed [127:0] q;
        num = 128'(signed'(p0)) * det + 128'(signed'(u)) * tn;
        q = num / 128'(signed'(det));
        return q[COORD_BITS-1:0];
    endfunction

    function automatic t_meet predict_meet(longint x1, longint y1, longint x2, longint y2,
                                           longint x3, longint y3, longint x4, longint y4);
        t_meet  m;
        longint ux, uy, vx, vy, l, r, det, tn;
        m = '{hit: 1'b0, how: HOW_NONE, px: '0, py: '0};
        ux = x2 - x1; uy = y2 - y1; vx = x4 - x3; vy = y4 - y3;
        // bounding-box reject
        if ((x1 < x2 ? x1 : x2) > (x3 > x4 ? x3 : x4) ||
            (x3 < x4 ? x3 : x4) > (x1 > x2 ? x1 : x2) ||
            (y1 < y2 ? y1 : y2) > (y3 > y4 ? y3 : y4) ||
            (y3 < y4 ? y3 : y4) > (y1 > y2 ? y1 : y2))
            return m;
        // touch at the end of the first segment
        l = cross2(ux, uy, x3 - x1, y3 - y1);
        r = cross2(ux, uy, x4 - x1, y4 - y1);
        if ((l == 0 && x2 == x3 && y2 == y3) || (r == 0 && x2 == x4 && y2 == y4)) begin
            m = '{hit: 1'b1, how: HOW_END1, px: COORD_BITS'(x2), py: COORD_BITS'(y2)};
            return m;
        end
        if (one_side(l, r)) return m;
        // touch at the start of the first segment
        l = cross2(ux, uy, x3 - x2, y3 - y2);
        r = cross2(ux, uy, x4 - x2, y4 - y2);
        if ((l == 0 && x1 == x3 && y1 == y3) || (r == 0 && x1 == x4 && y1 == y4)) begin
            m = '{hit: 1'b1, how: HOW_START1, px: COORD_BITS'(x1), py: COORD_BITS'(y1)};
            return m;
        end
        if (one_side(l, r)) return m;
        if (one_side(cross2(vx, vy, x3 - x1, y3 - y1), cross2(vx, vy, x3 - x2, y3 - y2)))
            return m;
        if (one_side(cross2(vx, vy, x4 - x1, y4 - y1), cross2(vx, vy, x4 - x2, y4 - y2)))
            return m;
        det = cross2(ux, uy, vx, vy);
        if (det == 0) begin
            m = '{hit: 1'b1, how: HOW_COLL, px: COORD_BITS'(x3), py: COORD_BITS'(y3)};
        end else begin
            tn = cross2(x3 - x1, y3 - y1, vx, vy);
            m = '{hit: 1'b1, how: HOW_CALC, px: cramer(x1, ux, tn, det),
                  py: cramer(y1, uy, tn, det)};
        end
        return m;
    endfunction

    // queue expectations on accepted requests, compare accepted results
    always @(posedge i_clk) begin
        t_meet e;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && !i_in_stall)
                meet_q = {meet_q, predict_meet(i_ax, i_ay, i_bx, i_by,
                                               i_cx, i_cy, i_dx, i_dy)};
            if (i_out_valid && !i_out_stall) begin
                if (meet_q.size() == 0) begin
                    $display("%0t: unexpected result hit=%0d how=%0d x=%0d y=%0d",
                             $time, i_hit, i_how_found, i_cross_x, i_cross_y);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = meet_q.pop_front();
                    if (i_hit !== e.hit || i_how_found !== e.how ||
                        i_cross_x !== e.px || i_cross_y !== e.py) begin
                        $display("%0t: expected hit=%0d how=%0d x=%0d y=%0d,",
                                 $time, e.hit, e.how, e.px, e.py,
                                 " got hit=%0d how=%0d x=%0d y=%0d",
                                 i_hit, i_how_found, i_cross_x, i_cross_y);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: test/segment_intersection_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_tb
// Directed segment pairs (extremes, touches, collinear overlap, crossings),
// then random and near-degenerate pairs, with random gaps on both sides and a
// long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module segment_intersection_tb;
    import segi_pkg::*;

    localparam int NUM_RANDOM  = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LATENCY     = 22;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic                         out_valid;
    logic                         out_stall;
    logic                         hit;
    logic [2:0]                   how_found;
    logic signed [COORD_BITS-1:0] cross_x, cross_y;
    int                           fail_count;
    int                           pending;
    int                           cycle_count;
    bit                           sending_done;
    bit                           hold_done;

    segment_intersection u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_ax(ax), .i_ay(ay), .i_bx(bx), .i_by(by),
        .i_cx(cx), .i_cy(cy), .i_dx(dx), .i_dy(dy),
        .o_valid(out_valid), .i_stall(out_stall), .o_hit(hit),
        .o_how_found(how_found), .o_cross_x(cross_x), .o_cross_y(cross_y)
    );

    segment_intersection_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_ax(ax), .i_ay(ay), .i_bx(bx), .i_by(by),
        .i_cx(cx), .i_cy(cy), .i_dx(dx), .i_dy(dy),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_hit(hit),
        .i_how_found(how_found), .i_cross_x(cross_x), .i_cross_y(cross_y),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one request after a random gap, hold it until taken
    task automatic send_pair(int x1, int y1, int x2, int y2,
                             int x3, int y3, int x4, int y4, bit no_gap);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16));
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ax <= COORD_BITS'(x1); ay <= COORD_BITS'(y1);
        bx <= COORD_BITS'(x2); by <= COORD_BITS'(y2);
        cx <= COORD_BITS'(x3); cy <= COORD_BITS'(y3);
        dx <= COORD_BITS'(x4); dy <= COORD_BITS'(y4);
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic int rnd_coord(int span);
        if (span == 0) return $urandom_range(0, 65535) - 32768;
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // stimulus
    initial begin
        int s, x1, y1, x2, y2, x3, y3, x4, y4, t;
        rst_n = 1'b0; in_valid = 1'b0; sending_done = 1'b0;
        {ax, ay, bx, by, cx, cy, dx, dy} = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // extremes, touches, collinear overlap, crossings, box reject
        send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0);
        send_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767, 0);
        send_pair(0, 0, 160, 160, 160, 160, 320, 0, 0);
        send_pair(0, 0, 160, 160, 320, 0, 160, 160, 0);
        send_pair(0, 0, 160, 160, 0, 0, -160, 80, 0);
        send_pair(0, 0, 160, 160, -160, 80, 0, 0, 0);
        send_pair(0, 0, 320, 0, 160, 0, 480, 0, 0);
        send_pair(0, 0, 320, 0, 400, 0, 480, 0, 0);
        send_pair(0, 0, 160, 160, 160, 0, 0, 160, 0);
        send_pair(0, 0, 30, 70, 17, 0, -5, 41, 0);
        send_pair(0, 0, -30, 70, -17, 0, 5, 41, 0);
        send_pair(0, 0, 100, 0, 0, 10, 100, 10, 0);
        send_pair(0, 0, 100, 100, 60, 40, 100, 0, 0);
        send_pair(0, 0, 100, 0, 50, 0, 50, 50, 0);
        send_pair(5, 5, 5, 5, 5, 5, 5, 5, 0);
        send_pair(-1, -1, -1, -1, 0, 0, 0, 0, 0);
        send_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767, 0);
        send_pair(-32768, 1, 32767, -1, 3, -32768, -3, 32767, 0);
        // random: mostly small crossing-prone pairs, some full range
        for (int i = 0; i < NUM_RANDOM; i++) begin
            t = $urandom_range(0, 9);
            s = (t < 6) ? 200 : (t < 8 ? 4 : 0);
            x1 = rnd_coord(s); y1 = rnd_coord(s); x2 = rnd_coord(s); y2 = rnd_coord(s);
            x3 = rnd_coord(s); y3 = rnd_coord(s); x4 = rnd_coord(s); y4 = rnd_coord(s);
            if ($urandom_range(0, 7) == 0) begin
                x3 = x2; y3 = y2;
            end else if ($urandom_range(0, 7) == 0) begin
                x4 = x1; y4 = y1;
            end else if ($urandom_range(0, 9) == 0) begin
                x3 = x1 + (x2 - x1) / 2; y3 = y1 + (y2 - y1) / 2;
                x4 = x2 + (x2 - x1) / 3; y4 = y2 + (y2 - y1) / 3;
                if (x4 > 32767 || x4 < -32768 || y4 > 32767 || y4 < -32768) begin
                    x4 = x2; y4 = y2;
                end
            end
            send_pair(x1, y1, x2, y2, x3, y3, x4, y4, i >= 100 && i < 160);
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // result side stalls, with one long hold-off while requests keep coming
    initial begin
        int wait_cycles;
        out_stall = 1'b1;
        hold_done = 1'b0;
        @(posedge clk iff rst_n);
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (!hold_done && cycle_count > 500) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end else if (out_valid && !out_stall) begin
                wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
                if (wait_cycles != 0) begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // cycle limit and verdict
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        wait (sending_done);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
